### hw/rtl/ple_pkg.sv
package ple_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_LOCATE = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Widths of the fixed payload fields
    localparam int POS_BITS  = 8;
    localparam int DATA_BITS = 32;

    // Per-cell update controls
    typedef struct packed {
        logic load;   // take the new word
        logic up;     // take the left neighbor's word
        logic down;   // take the right neighbor's word
    } cell_ctl_t;

endpackage

### hw/rtl/ple_cell.sv
module ple_cell
    import ple_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic [WORD_BITS-1:0] din,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    input  logic [WORD_BITS-1:0] key,
    output logic [WORD_BITS-1:0] word,
    output logic                 match
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Pick the source for this entry
    always_comb
    begin
        if (ctl.load)
        begin
            word_next = din;
        end
        else if (ctl.up)
        begin
            word_next = left_word;
        end
        else if (ctl.down)
        begin
            word_next = right_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key);

endmodule

### hw/rtl/ple_scan.sv
module ple_scan
    import ple_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CAPACITY-1:0] match_in,
    output logic                done,
    output logic [POS_BITS-1:0] found_at
);

    localparam int CHUNK  = 16;
    localparam int LOC_W  = 4;
    localparam int NCHUNK = (CAPACITY + CHUNK - 1) / CHUNK;
    localparam int VEC_W  = NCHUNK * CHUNK;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FW     = CH_W + LOC_W + 1;

    logic             active_reg;
    logic             active_next;
    logic [CH_W-1:0]  cnt_reg;
    logic [CH_W-1:0]  cnt_next;
    logic [VEC_W-1:0] vec_reg;
    logic [VEC_W-1:0] vec_next;

    logic             hit;
    logic [LOC_W-1:0] loc;
    logic             last;

    // Find the lowest match in the current chunk
    always_comb
    begin
        hit = 1'b0;
        loc = '0;
        for (int b = CHUNK - 1; b >= 0; b--)
        begin
            if (vec_reg[b])
            begin
                hit = 1'b1;
                loc = LOC_W'(b);
            end
        end
    end

    assign last     = (cnt_reg == CH_W'(NCHUNK - 1));
    assign done     = active_reg && (hit || last);
    assign found_at = hit ? POS_BITS'({1'b0, cnt_reg, loc} + FW'(1)) : '0;

    // Advance one chunk per cycle
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        vec_next    = vec_reg >> CHUNK;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            vec_next    = VEC_W'(match_in);
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

endmodule

### hw/rtl/positional_list_engine.sv
// channel  | handshake           | word
// ---------+---------------------+-----------------------------------------
// input    | in_valid, in_stall  | command, position, value
// output   | out_valid, out_stall| status, data_out, found_at, count
//
// Insert, delete and get: the cell row updates at accept, the result word is
// registered as pending and moves to the output register once that is free.
// Locate: the scan unit walks the registered match bits 16 cells per cycle,
// stops at the first hit or the last chunk; its result then goes the same way.
// Reset clears the fill count and control state; cell contents stay as is.
// A new word is taken while the previous result waits under out_stall.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [POS_BITS-1:0]  position,
    input  logic signed [DATA_BITS-1:0] value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic signed [DATA_BITS-1:0] data_out,
    output logic [POS_BITS-1:0]  found_at,
    output logic [POS_BITS-1:0]  count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W + 1 > POS_BITS + 1) ? CNT_W + 1 : POS_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;

    logic [1:0]           pend_status_reg;
    logic [1:0]           pend_status_next;
    logic [DATA_BITS-1:0] pend_data_reg;
    logic [DATA_BITS-1:0] pend_data_next;
    logic [POS_BITS-1:0]  pend_found_reg;
    logic [POS_BITS-1:0]  pend_found_next;
    logic [POS_BITS-1:0]  pend_count_reg;
    logic [POS_BITS-1:0]  pend_count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_status_reg;
    logic [DATA_BITS-1:0] out_data_reg;
    logic [POS_BITS-1:0]  out_found_reg;
    logic [POS_BITS-1:0]  out_count_reg;

    logic                 accept;
    logic                 out_load;
    logic [CW-1:0]        pos_w;
    logic [CW-1:0]        pos_m1;
    logic [CW-1:0]        fill_w;
    logic                 full;
    logic                 empty;
    logic                 ins_pos_ok;
    logic                 rd_pos_ok;
    logic                 ins_ok;
    logic                 del_ok;
    logic [WORD_BITS-1:0] key;
    logic [WORD_BITS-1:0] rd_word;

    cell_ctl_t            ctl [CAPACITY];
    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [CAPACITY-1:0]  cell_match;
    logic [CAPACITY-1:0]  match_vec;
    logic [CAPACITY-1:0]  rd_sel;

    logic                 scan_done;
    logic [POS_BITS-1:0]  scan_found;

    // Sign-extend a stored word into the 32-bit data field
    function automatic logic [DATA_BITS-1:0] to_field(input logic [WORD_BITS-1:0] w);
        logic [DATA_BITS-1:0] r;
        for (int b = 0; b < DATA_BITS; b++)
        begin
            r[b] = w[(b < WORD_BITS) ? b : WORD_BITS - 1];
        end
        return r;
    endfunction

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Bring the input word to the stored width
    always_comb
    begin
        key = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (b < DATA_BITS)
            begin
                key[b] = value[b[4:0]];
            end
        end
    end

    // Range checks
    assign pos_w      = CW'(position);
    assign fill_w     = CW'(fill_reg);
    assign pos_m1     = pos_w - CW'(1);
    assign full       = (fill_w == CW'(CAPACITY));
    assign empty      = (fill_reg == '0);
    assign ins_pos_ok = (pos_w != '0) && (pos_w <= fill_w + CW'(1));
    assign rd_pos_ok  = (pos_w != '0) && (pos_w <= fill_w);
    assign ins_ok     = accept && (command == CMD_INSERT) && !full && ins_pos_ok;
    assign del_ok     = accept && (command == CMD_DELETE) && !empty && rd_pos_ok;

    // Row of cells, one entry each
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        assign left_w  = (i == 0) ? '0 : cell_word[(i == 0) ? 0 : i - 1];
        assign right_w = cell_word[(i == CAPACITY - 1) ? i : i + 1];

        assign ctl[i].load = ins_ok && (CW'(i) == pos_m1);
        assign ctl[i].up   = ins_ok && (CW'(i) > pos_m1);
        assign ctl[i].down = del_ok && (CW'(i) >= pos_m1);

        assign rd_sel[i]    = (CW'(i) == pos_m1);
        assign match_vec[i] = cell_match[i] && (CW'(i) < fill_w);

        ple_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl[i]),
            .din        (key),
            .left_word  (left_w),
            .right_word (right_w),
            .key        (key),
            .word       (cell_word[i]),
            .match      (cell_match[i])
        );
    end

    // Select the addressed entry
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_sel[i])
            begin
                rd_word = rd_word | cell_word[i];
            end
        end
    end

    ple_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (command == CMD_LOCATE)),
        .match_in (match_vec),
        .done     (scan_done),
        .found_at (scan_found)
    );

    // Move a pending result into a free output register
    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || !out_stall);

    // Command decode and sequencing
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        pend_found_next  = pend_found_reg;
        pend_count_next  = pend_count_reg;
        out_valid_next   = out_valid_reg && out_stall;

        if (ins_ok)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_status_next = ST_OK;
                    pend_data_next   = '0;
                    pend_found_next  = '0;
                    pend_count_next  = POS_BITS'(fill_next);
                    state_next       = S_HOLD;
                    case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else if (!ins_pos_ok)
                            begin
                                pend_status_next = ST_BADPOS;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else if (!rd_pos_ok)
                            begin
                                pend_status_next = ST_BADPOS;
                            end
                            else
                            begin
                                pend_data_next = to_field(rd_word);
                            end
                        end
                        CMD_GET:
                        begin
                            if (!rd_pos_ok)
                            begin
                                pend_status_next = ST_BADPOS;
                            end
                            else
                            begin
                                pend_data_next = to_field(rd_word);
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    pend_found_next = scan_found;
                    state_next      = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        pend_found_reg  <= pend_found_next;
        pend_count_reg  <= pend_count_next;
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_data_reg;
            out_found_reg  <= pend_found_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_data_reg;
    assign found_at  = out_found_reg;
    assign count     = out_count_reg;

    // Fill never passes the capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // A new output word only comes from a pending result
    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("output word without pending result");

    // The scan unit finishes only while a locate is in flight
    a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == S_SCAN))
        else $error("scan finished outside locate");

    // A good insert grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

endmodule
